FILE: sv/mbd_pkg.sv
package mbd_pkg;

   // Widths of the configuration registers and of the result fields.
   localparam int unsigned STABLE_W = 4;
   localparam int unsigned MAXEV_W  = 4;
   localparam int unsigned BUTTON_W = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 4;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_SAMPLES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVEL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EVENTS     = 2'd2;

   // Register reset values.
   localparam logic [STABLE_W-1:0] STABLE_RESET = 4'd3;
   localparam logic                ACTIVE_RESET = 1'b0;
   localparam logic [MAXEV_W-1:0]  MAXEV_RESET  = 4'd11;

   // Raw level held by every button after reset (released for active low).
   localparam logic LEVEL_RESET = 1'b1;

   // What one button cell reports in the cycle of a sample word.
   typedef struct packed {
      logic debounced;
      logic flip;
   } cell_stat_type;

endpackage

FILE: sv/mbd_if.sv
// Request channel: one word of raw button levels.
interface mbd_req_if #(
   parameter int unsigned NUM_BUTTONS = 11
);
   logic                   valid;
   logic                   ready;
   logic [NUM_BUTTONS-1:0] raw_levels;

   modport source (output valid, output raw_levels, input ready);
   modport sink   (input valid, input raw_levels, output ready);
endinterface

// Response channel: one event word per reported debounced change, or one word with no event for a quiet tick.
interface mbd_rsp_if #(
   parameter int unsigned NUM_BUTTONS = 11
);
   logic                   valid;
   logic                   ready;
   logic                   event_valid;
   logic [3:0]             event_button;
   logic                   event_pressed;
   logic [NUM_BUTTONS-1:0] pressed_mask;
   logic                   last;

   modport source (output valid, output event_valid, output event_button,
                   output event_pressed, output pressed_mask, output last,
                   input ready);
   modport sink   (input valid, input event_valid, input event_button,
                   input event_pressed, input pressed_mask, input last,
                   output ready);
endinterface

FILE: sv/mbd_cell.sv
module mbd_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          raw,
   input  logic [mbd_pkg::STABLE_W-1:0]  stable_samples,
   output mbd_pkg::cell_stat_type        stat
);
   import mbd_pkg::*;

   logic                deb_ff, deb_in;
   logic                cand_ff, cand_in;
   logic [STABLE_W-1:0] cnt_ff, cnt_in;
   logic [STABLE_W-1:0] cnt_step;
   logic                flip;

   // Next state of this button for the sample word now offered.
   always_comb begin
      cand_in  = cand_ff;
      cnt_step = cnt_ff;
      flip     = 1'b0;
      deb_in   = deb_ff;
      cnt_in   = cnt_ff;
      if (raw == deb_ff) begin
         cand_in = raw;
         cnt_in  = '0;
      end else begin
         if (raw == cand_ff) begin
            if (cnt_ff < stable_samples) begin
               cnt_step = cnt_ff + STABLE_W'(1);
            end
         end else begin
            cand_in  = raw;
            cnt_step = STABLE_W'(1);
         end
         flip = (cnt_step >= stable_samples);
         if (flip) begin
            deb_in = raw;
            cnt_in = '0;
         end else begin
            cnt_in = cnt_step;
         end
      end
   end

   assign stat.debounced = deb_in;
   assign stat.flip      = flip;

   // Button state advances once per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff  <= LEVEL_RESET;
         cand_ff <= LEVEL_RESET;
         cnt_ff  <= '0;
      end else if (load) begin
         deb_ff  <= deb_in;
         cand_ff <= cand_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

FILE: sv/mbd_emit.sv
module mbd_emit #(
   parameter int unsigned NUM_BUTTONS = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [NUM_BUTTONS-1:0]        flips,
   input  logic [NUM_BUTTONS-1:0]        pmask,
   input  logic [mbd_pkg::MAXEV_W-1:0]   event_limit,
   output logic                          load_ready,
   input  logic                          out_ready,
   output logic                          out_valid,
   output logic                          out_event_valid,
   output logic [mbd_pkg::BUTTON_W-1:0]  out_event_button,
   output logic                          out_event_pressed,
   output logic [NUM_BUTTONS-1:0]        out_pressed_mask,
   output logic                          out_last
);
   import mbd_pkg::*;

   localparam int unsigned CW = $clog2(NUM_BUTTONS + 1);
   localparam int unsigned KW = (CW > MAXEV_W) ? CW : MAXEV_W;

   logic                   work_ff;
   logic [NUM_BUTTONS-1:0] pend_ff, pend_in;
   logic [NUM_BUTTONS-1:0] pmask_ff;
   logic [CW-1:0]          sent_ff;

   logic                   rsp_valid_ff;
   logic                   ev_valid_ff;
   logic [BUTTON_W-1:0]    ev_button_ff;
   logic                   ev_pressed_ff;
   logic [NUM_BUTTONS-1:0] mask_ff;
   logic                   last_ff;

   logic                   found;
   logic [BUTTON_W-1:0]    idx;
   logic [NUM_BUTTONS-1:0] onehot;
   logic [NUM_BUTTONS-1:0] rest;
   logic                   limit_hit;
   logic                   last_now;
   logic                   out_free;
   logic                   fire;
   logic                   done;

   // Lowest pending button goes out next.
   always_comb begin
      found  = 1'b0;
      idx    = '0;
      onehot = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (!found && pend_ff[i]) begin
            found     = 1'b1;
            idx       = BUTTON_W'(i);
            onehot[i] = 1'b1;
         end
      end
   end

   assign rest      = pend_ff & ~onehot;
   assign limit_hit = (KW'(sent_ff) + KW'(1)) >= KW'(event_limit);
   assign last_now  = !found || (rest == '0) || limit_hit;
   assign out_free  = !rsp_valid_ff || out_ready;
   assign fire      = work_ff && out_free;
   assign done      = fire && last_now;
   assign load_ready = !work_ff || done;

   // A tick with a report limit of zero reports nothing.
   assign pend_in = (event_limit != '0) ? flips : '0;

   // Work stage: the events of one tick waiting to be sent.
   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= 1'b0;
      end else if (load) begin
         work_ff <= 1'b1;
      end else if (done) begin
         work_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pend_ff  <= pend_in;
         pmask_ff <= pmask;
         sent_ff  <= '0;
      end else if (fire) begin
         pend_ff <= rest;
         sent_ff <= sent_ff + CW'(1);
      end
   end

   // Output register decouples the sink from the work stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         ev_valid_ff   <= found;
         ev_button_ff  <= idx;
         ev_pressed_ff <= found && |(pmask_ff & onehot);
         mask_ff       <= pmask_ff;
         last_ff       <= last_now;
      end
   end

   assign out_valid         = rsp_valid_ff;
   assign out_event_valid   = ev_valid_ff;
   assign out_event_button  = ev_button_ff;
   assign out_event_pressed = ev_pressed_ff;
   assign out_pressed_mask  = mask_ff;
   assign out_last          = last_ff;

endmodule

FILE: sv/multi_button_debouncer_top.sv
// A tick's first result word moves from the work stage to the output register before
// it is offered. A tick yields one word per reported event, at least one, at most NUM_BUTTONS;
// the serial event emitter sends them in turn; the cells update on each accepted tick.
// A new tick is accepted in the cycle that the last word of the previous one is sent.
// Reset (synchronous, active high) sets every button to the released raw level with a
// zero count and loads the register reset values.
module multi_button_debouncer_top #(
   parameter int unsigned NUM_BUTTONS = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   mbd_req_if.sink                         req_ch,
   mbd_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [mbd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mbd_pkg::*;

   logic [STABLE_W-1:0]    stable_ff;
   logic                   active_ff;
   logic [MAXEV_W-1:0]     maxev_ff;

   logic                   load;
   logic                   load_ready;
   cell_stat_type          stat [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] flips;
   logic [NUM_BUTTONS-1:0] pmask;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= STABLE_RESET;
         active_ff <= ACTIVE_RESET;
         maxev_ff  <= MAXEV_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STABLE_SAMPLES: stable_ff <= csr_wdata[STABLE_W-1:0];
            CSR_ACTIVE_LEVEL:   active_ff <= csr_wdata[0];
            CSR_MAX_EVENTS:     maxev_ff  <= csr_wdata[MAXEV_W-1:0];
            default: ;
         endcase
      end
   end

   assign load         = req_ch.valid && load_ready;
   assign req_ch.ready = load_ready;

   // One cell per button.
   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_cell
      mbd_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .load           (load),
         .raw            (req_ch.raw_levels[g]),
         .stable_samples (stable_ff),
         .stat           (stat[g])
      );
      assign flips[g] = stat[g].flip;
      assign pmask[g] = (stat[g].debounced == active_ff);
   end

   mbd_emit #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_emit (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .flips             (flips),
      .pmask             (pmask),
      .event_limit       (maxev_ff),
      .load_ready        (load_ready),
      .out_ready         (rsp_ch.ready),
      .out_valid         (rsp_ch.valid),
      .out_event_valid   (rsp_ch.event_valid),
      .out_event_button  (rsp_ch.event_button),
      .out_event_pressed (rsp_ch.event_pressed),
      .out_pressed_mask  (rsp_ch.pressed_mask),
      .out_last          (rsp_ch.last)
   );

endmodule

FILE: sim/mbd_event_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and register ports of the debouncer, predicts the
// event words of every accepted sample word and compares them in order.
module mbd_event_checker #(
   parameter int unsigned NUM_BUTTONS = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   mbd_req_if                              req_mon,
   mbd_rsp_if                              rsp_mon,
   input  logic                            csr_we,
   input  logic [mbd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              backlog
);
   import mbd_pkg::*;

   typedef struct packed {
      logic                   event_valid;
      logic [BUTTON_W-1:0]    event_button;
      logic                   event_pressed;
      logic [NUM_BUTTONS-1:0] pressed_mask;
      logic                   last;
   } event_word_type;

   // Predicted button state and register copies.
   logic [NUM_BUTTONS-1:0] settled_lvl;
   logic [NUM_BUTTONS-1:0] candidate_lvl;
   logic [STABLE_W-1:0]    run_len [NUM_BUTTONS];
   logic [STABLE_W-1:0]    threshold;
   logic                   press_lvl;
   logic [MAXEV_W-1:0]     event_cap;

   event_word_type pending_words [$];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // Advances every button by one sample and queues the words that the tick yields.
   task automatic debounce_tick(input logic [NUM_BUTTONS-1:0] raw);
      logic [BUTTON_W-1:0]    flip_btn [NUM_BUTTONS];
      logic                   flip_prs [NUM_BUTTONS];
      int                     n_flips;
      logic [NUM_BUTTONS-1:0] mask;
      event_word_type         w;
      n_flips = 0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (raw[i] == settled_lvl[i]) begin
            candidate_lvl[i] = raw[i];
            run_len[i] = '0;
         end else begin
            // A repeat of the candidate extends the run; anything else restarts it.
            if (raw[i] == candidate_lvl[i]) begin
               if (run_len[i] < threshold)
                  run_len[i] = run_len[i] + STABLE_W'(1);
            end else begin
               candidate_lvl[i] = raw[i];
               run_len[i] = STABLE_W'(1);
            end
            // The flip always happens; only the report is limited by the cap.
            if (run_len[i] >= threshold) begin
               settled_lvl[i] = raw[i];
               run_len[i] = '0;
               if (n_flips < event_cap) begin
                  flip_btn[n_flips] = BUTTON_W'(i);
                  flip_prs[n_flips] = (raw[i] == press_lvl);
                  n_flips++;
               end
            end
         end
      end
      mask = ~(settled_lvl ^ {NUM_BUTTONS{press_lvl}});
      // A quiet tick still gives one word carrying the mask.
      if (n_flips == 0) begin
         w.event_valid   = 1'b0;
         w.event_button  = '0;
         w.event_pressed = 1'b0;
         w.pressed_mask  = mask;
         w.last          = 1'b1;
         pending_words.push_back(w);
      end else begin
         for (int k = 0; k < n_flips; k++) begin
            w.event_valid   = 1'b1;
            w.event_button  = flip_btn[k];
            w.event_pressed = flip_prs[k];
            w.pressed_mask  = mask;
            w.last          = (k == n_flips - 1);
            pending_words.push_back(w);
         end
      end
   endtask

   // Compares one accepted response word with the oldest prediction.
   task automatic compare_word();
      event_word_type want;
      if (pending_words.size() == 0) begin
         report_mismatch("word with nothing pending (mask)", rsp_mon.pressed_mask, -1);
      end else begin
         want = pending_words.pop_front();
         if (rsp_mon.event_valid !== want.event_valid)
            report_mismatch("event_valid", rsp_mon.event_valid, want.event_valid);
         if (rsp_mon.event_button !== want.event_button)
            report_mismatch("event_button", rsp_mon.event_button, want.event_button);
         if (rsp_mon.event_pressed !== want.event_pressed)
            report_mismatch("event_pressed", rsp_mon.event_pressed, want.event_pressed);
         if (rsp_mon.pressed_mask !== want.pressed_mask)
            report_mismatch("pressed_mask", rsp_mon.pressed_mask, want.pressed_mask);
         if (rsp_mon.last !== want.last)
            report_mismatch("last", rsp_mon.last, want.last);
      end
   endtask

   // Responses are compared before the new tick is queued, since a tick cannot
   // answer in the cycle it is accepted. A register write takes effect after the
   // tick accepted at the same edge, as in the block.
   always @(posedge clock) begin
      if (reset) begin
         settled_lvl   = {NUM_BUTTONS{LEVEL_RESET}};
         candidate_lvl = {NUM_BUTTONS{LEVEL_RESET}};
         for (int i = 0; i < NUM_BUTTONS; i++)
            run_len[i] = '0;
         threshold  = STABLE_RESET;
         press_lvl  = ACTIVE_RESET;
         event_cap  = MAXEV_RESET;
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready)
            compare_word();
         if (req_mon.valid && req_mon.ready)
            debounce_tick(req_mon.raw_levels);
         if (csr_we) begin
            case (csr_index)
               CSR_STABLE_SAMPLES: threshold = csr_wdata[STABLE_W-1:0];
               CSR_ACTIVE_LEVEL:   press_lvl = csr_wdata[0];
               CSR_MAX_EVENTS:     event_cap = csr_wdata[MAXEV_W-1:0];
               default: ;
            endcase
         end
      end
      backlog = pending_words.size();
   end

endmodule

FILE: sim/multi_button_debouncer_top_tb.sv
`timescale 1ns / 1ps

module multi_button_debouncer_top_tb;
   import mbd_pkg::*;

   localparam int unsigned NUM_BUTTONS = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 600000;
   localparam int LONG_HOLD    = 300;
   localparam int PHASES       = 6;
   localparam int PHASE_WORDS  = 60;
   localparam int SETTLE_CYCLES = 4;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    backlog;
   int                    cycle_count = 0;
   bit                    hold_request = 1'b0;
   logic [NUM_BUTTONS-1:0] intent;

   mbd_req_if #(.NUM_BUTTONS(NUM_BUTTONS)) req_ch ();
   mbd_rsp_if #(.NUM_BUTTONS(NUM_BUTTONS)) rsp_ch ();

   multi_button_debouncer_top #(.NUM_BUTTONS(NUM_BUTTONS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mbd_event_checker #(.NUM_BUTTONS(NUM_BUTTONS)) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   // Held presses with contact bounce on top, and now and then a word of pure noise.
   function automatic logic [NUM_BUTTONS-1:0] next_word();
      if ($urandom_range(0, 99) < 12)
         return NUM_BUTTONS'($urandom);
      intent = intent ^ NUM_BUTTONS'($urandom & $urandom & $urandom & $urandom);
      return intent ^ NUM_BUTTONS'($urandom & $urandom & $urandom);
   endfunction

   // Offers one sample word after an optional gap and returns once it is taken.
   task automatic send_word(input logic [NUM_BUTTONS-1:0] raw, input int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.raw_levels <= raw;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted word has come back.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [STABLE_W-1:0] stable, input logic level,
                               input logic [MAXEV_W-1:0] cap);
      csr_write(CSR_STABLE_SAMPLES, CSR_DATA_W'(stable));
      csr_write(CSR_ACTIVE_LEVEL, CSR_DATA_W'(level));
      csr_write(CSR_MAX_EVENTS, CSR_DATA_W'(cap));
      csr_we <= 1'b0;
   endtask

   // Response side: random back-pressure, calm stretches, and one long hold on request.
   initial begin
      int gap;
      int calm;
      rsp_ch.ready <= 1'b0;
      calm = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            gap = (calm > 0) ? 0 : idle_gap();
            if (calm > 0)
               calm--;
            else if ($urandom_range(0, 39) == 0)
               calm = $urandom_range(20, 80);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Request side and register writes.
   initial begin
      int                  calm_tx;
      int                  gap;
      logic [STABLE_W-1:0] stable;
      logic                level;
      logic [MAXEV_W-1:0]  cap;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.raw_levels <= '0;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      intent  = '1;
      calm_tx = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: an idle word, all buttons pressed together, then all released.
      send_word(11'h7FF, idle_gap());
      repeat (3) send_word(11'h000, idle_gap());
      repeat (3) send_word(11'h7FF, idle_gap());
      settle();

      // Build runs under a high threshold, then lower it below the runs already held,
      // with the event cap small enough that most flips go unreported.
      apply_config(4'd5, 1'b0, 4'd11);
      repeat (3) send_word(11'h000, idle_gap());
      settle();
      apply_config(4'd2, 1'b0, 4'd3);
      send_word(11'h000, idle_gap());
      settle();

      // A write to the unused register index must change nothing.
      csr_write(CSR_UNUSED, '1);
      csr_we <= 1'b0;
      send_word(11'h000, idle_gap());
      settle();

      // Zero threshold flips at once; zero cap hides every event; pressed is high now.
      apply_config(4'd0, 1'b1, 4'd0);
      send_word(11'h7FF, idle_gap());
      send_word(11'h555, idle_gap());
      settle();

      // Highest threshold, then a cap above the button count with all eleven flipping.
      apply_config(4'd15, 1'b0, 4'd15);
      repeat (2) send_word(11'h2AA, idle_gap());
      settle();
      apply_config(4'd1, 1'b0, 4'd15);
      send_word(11'h000, idle_gap());
      send_word(11'h7FF, idle_gap());
      settle();

      // Random phases, each under its own register settings.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin stable = 4'd1;  level = 1'b1; cap = 4'd15; end
            1: begin stable = 4'd15; level = 1'b0; cap = 4'd1;  end
            2: begin stable = 4'd0;  level = 1'b1; cap = 4'd11; end
            3: begin stable = 4'd2;  level = 1'b0; cap = 4'd0;  end
            default: begin
               stable = ($urandom_range(0, 3) == 0) ? STABLE_W'($urandom_range(0, 15))
                                                    : STABLE_W'($urandom_range(1, 4));
               level  = 1'($urandom);
               cap    = MAXEV_W'($urandom_range(0, 15));
            end
         endcase
         apply_config(stable, level, cap);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            // Long response hold while words keep coming, so the input backs up.
            if (p == 2 && k == 10)
               hold_request = 1'b1;
            // Let the block drain completely before carrying on.
            if (p == 4 && k == 30)
               settle();
            gap = (calm_tx > 0) ? 0 : idle_gap();
            if (calm_tx > 0)
               calm_tx--;
            else if ($urandom_range(0, 29) == 0)
               calm_tx = $urandom_range(15, 50);
            send_word(next_word(), gap);
         end
         settle();
      end

      if (fail_count == 0 && backlog == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
